@@ rtl/mfd_pkg.sv @@
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants of the marked frame deframer.
// ----------------------------------------------------------------------------
package mfd_pkg;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_GOT_S  = 2'd1,
    PH_HEADER = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CL_PLAIN   = 2'd0,
    CL_OPEN    = 2'd1,
    CL_FINAL   = 2'd2,
    CL_DISCARD = 2'd3
  } class_t;

  typedef enum logic [2:0] {
    K_SKIP    = 3'd0,
    K_HEADER  = 3'd1,
    K_META    = 3'd2,
    K_PAYLOAD = 3'd3,
    K_ORPHAN  = 3'd4,
    K_FULL    = 3'd5
  } kind_t;

  localparam logic [7:0]  MARK_S       = 8'h53;
  localparam logic [7:0]  MARK_C       = 8'h43;
  localparam logic [7:0]  FLAG_START   = 8'h02;
  localparam logic [7:0]  FLAG_CONT    = 8'h04;
  localparam logic [7:0]  STATE_FINAL  = 8'd2;
  localparam logic [31:0] HASH_MUL     = 32'd131;
  localparam logic [4:0]  HDR_LAST     = 5'd14;

  // result word as written into the output register
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] frame_id;
    logic [31:0] sequence_res;
    logic [7:0]  msg_type;
    logic [7:0]  frame_flags;
    logic [7:0]  frame_status;
    logic [15:0] meta_length;
    logic [15:0] payload_length;
    logic [31:0] rolling_hash;
    logic        frame_end;
    logic        message_done;
  } result_t;

  // id table lookup summary handed to the parser
  typedef struct packed {
    logic hit;
    logic has_free;
  } lookup_t;

  // table update request from the parser
  typedef struct packed {
    logic open;
    logic close;
  } tbl_cmd_t;

endpackage

@@ rtl/mfd_id_table.sv @@
// ----------------------------------------------------------------------------
// mfd_id_table
// Table of open fragment ids with a parallel compare and lowest-free-slot pick.
// ----------------------------------------------------------------------------
module mfd_id_table #(
  parameter int OPEN_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        id,
  input  mfd_pkg::tbl_cmd_t  cmd,
  output mfd_pkg::lookup_t   look
);

  logic [OPEN_SLOTS-1:0] valid;
  logic [31:0]           ids [OPEN_SLOTS];
  logic [OPEN_SLOTS-1:0] match;
  logic [OPEN_SLOTS-1:0] free_pick;

  // parallel compare against every open id
  always_comb begin
    for (int i = 0; i < OPEN_SLOTS; i++) begin
      match[i] = valid[i] && (ids[i] == id);
    end
  end

  // one-hot lowest free slot
  assign free_pick = ~valid & (valid + 1'b1);

  assign look.hit      = |match;
  assign look.has_free = |free_pick;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.close) begin
      valid <= valid & ~match;
    end else if (cmd.open) begin
      valid <= valid | free_pick;
    end
  end

  // id storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < OPEN_SLOTS; i++) begin
      if (cmd.open && free_pick[i]) begin
        ids[i] <= id;
      end
    end
  end

endmodule

@@ rtl/mfd_parser.sv @@
// ----------------------------------------------------------------------------
// mfd_parser
// Marker hunt, header collection, hash update and body counting per byte.
// ----------------------------------------------------------------------------
module mfd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         in_byte,
  input  mfd_pkg::lookup_t   look,
  output logic [31:0]        cur_id,
  output mfd_pkg::tbl_cmd_t  cmd,
  output logic               res_valid,
  output mfd_pkg::result_t   res
);

  mfd_pkg::phase_t phase, phase_next;
  mfd_pkg::class_t frame_class, frame_class_next;
  logic [4:0]  header_index;
  logic [63:0] header_store;
  logic [39:0] header_lengths;
  logic [7:0]  hdr_flags;
  logic [7:0]  hdr_type;
  logic [16:0] bytes_left, bytes_left_next;
  logic [31:0] hash_value, hash_next;
  logic [31:0] hash_mul;

  // completed header fields (last header byte is the state byte)
  logic [31:0] h_id, h_seq;
  logic [15:0] h_meta, h_pay;
  logic [7:0]  h_state;
  logic [16:0] total;
  logic        last_hdr, is_final, done;
  mfd_pkg::kind_t hdr_kind;

  assign h_id    = header_store[31:0];
  assign h_seq   = header_store[63:32];
  assign h_meta  = header_lengths[15:0];
  assign h_pay   = header_lengths[31:16];
  assign h_state = in_byte;
  assign total   = {1'b0, h_meta} + {1'b0, h_pay};
  assign cur_id  = h_id;
  assign last_hdr = (phase == mfd_pkg::PH_HEADER) && (header_index == mfd_pkg::HDR_LAST);
  assign is_final = (h_state == mfd_pkg::STATE_FINAL);
  assign hash_mul = hash_value * mfd_pkg::HASH_MUL;
  assign hash_next = hash_mul ^ h_id ^ h_seq ^ {24'd0, h_state} ^ {24'd0, hdr_flags};

  // frame classification at the end of the header
  always_comb begin
    frame_class_next = frame_class;
    cmd = '0;
    hdr_kind = mfd_pkg::K_HEADER;
    if (take && last_hdr) begin
      priority if ((hdr_flags & mfd_pkg::FLAG_START) != 8'd0) begin
        if (is_final) begin
          cmd.close = 1'b1;
          frame_class_next = mfd_pkg::CL_FINAL;
        end else if (look.hit) begin
          frame_class_next = mfd_pkg::CL_OPEN;
        end else if (!look.has_free) begin
          frame_class_next = mfd_pkg::CL_DISCARD;
          hdr_kind = mfd_pkg::K_FULL;
        end else begin
          cmd.open = 1'b1;
          frame_class_next = mfd_pkg::CL_OPEN;
        end
      end else if ((hdr_flags & mfd_pkg::FLAG_CONT) != 8'd0) begin
        if (!look.hit) begin
          frame_class_next = mfd_pkg::CL_DISCARD;
          hdr_kind = mfd_pkg::K_ORPHAN;
        end else if (is_final) begin
          cmd.close = 1'b1;
          frame_class_next = mfd_pkg::CL_FINAL;
        end else begin
          frame_class_next = mfd_pkg::CL_OPEN;
        end
      end else begin
        frame_class_next = mfd_pkg::CL_PLAIN;
      end
    end
  end

  assign done = (frame_class_next == mfd_pkg::CL_PLAIN) ||
                (frame_class_next == mfd_pkg::CL_FINAL);

  // next phase, body count and result
  always_comb begin
    phase_next = phase;
    bytes_left_next = bytes_left;
    res_valid = 1'b0;
    res = '0;
    unique case (phase)
      mfd_pkg::PH_HUNT: begin
        if (in_byte == mfd_pkg::MARK_S) begin
          phase_next = mfd_pkg::PH_GOT_S;
        end else begin
          res_valid = 1'b1;
          res.kind = mfd_pkg::K_SKIP;
          res.data_byte = 8'd1;
        end
      end
      mfd_pkg::PH_GOT_S: begin
        if (in_byte == mfd_pkg::MARK_C) begin
          phase_next = mfd_pkg::PH_HEADER;
        end else if (in_byte == mfd_pkg::MARK_S) begin
          res_valid = 1'b1;
          res.kind = mfd_pkg::K_SKIP;
          res.data_byte = 8'd1;
        end else begin
          phase_next = mfd_pkg::PH_HUNT;
          res_valid = 1'b1;
          res.kind = mfd_pkg::K_SKIP;
          res.data_byte = 8'd2;
        end
      end
      mfd_pkg::PH_HEADER: begin
        if (last_hdr) begin
          bytes_left_next = total;
          phase_next = (total == 17'd0) ? mfd_pkg::PH_HUNT : mfd_pkg::PH_BODY;
          res_valid = 1'b1;
          res.kind = hdr_kind;
          res.frame_id = h_id;
          res.sequence_res = h_seq;
          res.msg_type = hdr_type;
          res.frame_flags = hdr_flags;
          res.frame_status = h_state;
          res.meta_length = h_meta;
          res.payload_length = h_pay;
          res.rolling_hash = hash_next;
          if (frame_class_next == mfd_pkg::CL_DISCARD) begin
            res.frame_end = 1'b1;
          end else begin
            res.frame_end = (total == 17'd0);
            res.message_done = (total == 17'd0) && done;
          end
        end
      end
      mfd_pkg::PH_BODY: begin
        if (bytes_left == 17'd0) begin
          phase_next = mfd_pkg::PH_HUNT;
        end else begin
          bytes_left_next = bytes_left - 17'd1;
          if (bytes_left_next == 17'd0) phase_next = mfd_pkg::PH_HUNT;
          res_valid = (frame_class != mfd_pkg::CL_DISCARD);
          res.kind = (bytes_left > {1'b0, h_pay}) ? mfd_pkg::K_META : mfd_pkg::K_PAYLOAD;
          res.data_byte = in_byte;
          res.frame_id = h_id;
          res.sequence_res = h_seq;
          res.msg_type = hdr_type;
          res.frame_flags = hdr_flags;
          res.frame_status = header_lengths[39:32];
          res.meta_length = h_meta;
          res.payload_length = h_pay;
          res.rolling_hash = hash_value;
          res.frame_end = (bytes_left_next == 17'd0);
          res.message_done = (bytes_left_next == 17'd0) &&
                             ((frame_class == mfd_pkg::CL_PLAIN) ||
                              (frame_class == mfd_pkg::CL_FINAL));
        end
      end
      default: begin
        phase_next = mfd_pkg::PH_HUNT;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mfd_pkg::PH_HUNT;
      header_index <= '0;
      bytes_left <= '0;
      frame_class <= mfd_pkg::CL_PLAIN;
      hash_value <= '0;
    end else if (take) begin
      phase <= phase_next;
      bytes_left <= bytes_left_next;
      frame_class <= frame_class_next;
      if (last_hdr) hash_value <= hash_next;
      if (phase == mfd_pkg::PH_HEADER) begin
        header_index <= last_hdr ? 5'd0 : header_index + 5'd1;
      end else begin
        header_index <= '0;
      end
    end
  end

  // header field capture
  always_ff @(posedge clk) begin
    if (rst) begin
      header_store <= '0;
      header_lengths <= '0;
      hdr_flags <= '0;
      hdr_type <= '0;
    end else if (take) begin
      if (phase == mfd_pkg::PH_GOT_S && in_byte == mfd_pkg::MARK_C) begin
        header_store <= '0;
        header_lengths <= '0;
        hdr_flags <= '0;
        hdr_type <= '0;
      end else if (phase == mfd_pkg::PH_HEADER) begin
        if (header_index == 5'd0) hdr_flags <= in_byte;
        else if (header_index == 5'd1) hdr_type <= in_byte;
        else if (header_index <= 5'd9) header_store[8*(header_index-5'd2) +: 8] <= in_byte;
        else header_lengths[8*(header_index-5'd10) +: 8] <= in_byte;
      end
    end
  end

endmodule

@@ rtl/marked_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// marked_frame_deframer_top
// Byte-serial frame parser with marker hunt, header decode and id tracking.
//
//  channel | signals                         | word
//  in      | in_valid / in_ready             | in_byte
//  out     | out_valid / out_ready           | kind .. message_done
//
// One byte is taken per cycle while in_ready is high; a result appears in the cycle after its byte.
// The byte logic is one pass: phase update, id compare over all slots, hash.
// Input is ready whenever the output register is empty or being drained.
// Reset clears phase, counters, hash and all table valid bits.
// ----------------------------------------------------------------------------
module marked_frame_deframer_top #(
  parameter int OPEN_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  data_byte,
  output logic [31:0] frame_id,
  output logic [31:0] sequence_res,
  output logic [7:0]  msg_type,
  output logic [7:0]  frame_flags,
  output logic [7:0]  frame_status,
  output logic [15:0] meta_length,
  output logic [15:0] payload_length,
  output logic [31:0] rolling_hash,
  output logic        frame_end,
  output logic        message_done
);

  logic              take;
  logic [31:0]       cur_id;
  mfd_pkg::lookup_t  look;
  mfd_pkg::tbl_cmd_t cmd;
  logic              res_valid;
  mfd_pkg::result_t  res, out_reg;

  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  mfd_id_table #(.OPEN_SLOTS(OPEN_SLOTS)) u_table (
    .clk(clk), .rst(rst), .id(cur_id), .cmd(cmd), .look(look)
  );

  mfd_parser u_parser (
    .clk(clk), .rst(rst), .take(take), .in_byte(in_byte), .look(look),
    .cur_id(cur_id), .cmd(cmd), .res_valid(res_valid), .res(res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) out_reg <= res;
  end

  assign kind = out_reg.kind;
  assign data_byte = out_reg.data_byte;
  assign frame_id = out_reg.frame_id;
  assign sequence_res = out_reg.sequence_res;
  assign msg_type = out_reg.msg_type;
  assign frame_flags = out_reg.frame_flags;
  assign frame_status = out_reg.frame_status;
  assign meta_length = out_reg.meta_length;
  assign payload_length = out_reg.payload_length;
  assign rolling_hash = out_reg.rolling_hash;
  assign frame_end = out_reg.frame_end;
  assign message_done = out_reg.message_done;

endmodule

@@ rtl/mfd_checker.sv @@
// ----------------------------------------------------------------------------
// mfd_checker
// Port-level checks on the deframer output.
// ----------------------------------------------------------------------------
module mfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] data_byte,
  input logic       frame_end,
  input logic       message_done
);

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte))
    else $error("output changed under stall");

  // no new result without an accepted byte
  a_cause: assert property (@(posedge clk) disable iff (rst)
    !out_valid |=> !out_valid || $past(in_valid && in_ready))
    else $error("result without input");

  // done only on frame end
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_done |-> frame_end)
    else $error("message done without frame end");

  // skip count is one or two
  a_skip: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == mfd_pkg::K_SKIP |->
      (data_byte == 8'd1 || data_byte == 8'd2) && !frame_end)
    else $error("bad skip result");

endmodule

bind marked_frame_deframer_top mfd_checker u_mfd_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
  .data_byte(data_byte), .frame_end(frame_end), .message_done(message_done)
);
